### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Checks on the rising edge of clk_i. Reset is rst_ni, active low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check held off while rst_ni is low
`define DHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check also during reset
`define DHC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DHC_ASSERT(lbl, prop, msg)
`define DHC_ASSERT_NR(lbl, prop, msg)
`endif

`endif

### design/dhc_pkg.sv
// ----------------------------------------------------------------------------
// dhc_pkg
// Types, command codes and helpers of the differential drive heading
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dhc_pkg;

  // command codes
  localparam logic [3:0] CMD_TICK       = 4'd0;
  localparam logic [3:0] CMD_TANK       = 4'd1;
  localparam logic [3:0] CMD_ARCADE     = 4'd2;
  localparam logic [3:0] CMD_STRAIGHT   = 4'd3;
  localparam logic [3:0] CMD_TURN       = 4'd4;
  localparam logic [3:0] CMD_AUTORUN    = 4'd5;
  localparam logic [3:0] CMD_AUTODONE   = 4'd6;
  localparam logic [3:0] CMD_MOVE       = 4'd7;
  localparam logic [3:0] CMD_STOP       = 4'd8;
  localparam logic [3:0] CMD_ZERO       = 4'd9;
  localparam logic [3:0] CMD_STATEAUTO  = 4'd10;
  localparam logic [3:0] CMD_STATEOTHER = 4'd11;

  // configuration register indexes
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;
  localparam logic [CFG_AW-1:0] CFG_RECOVER_GAIN = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_TURN_GAIN    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_TURN_LIMIT   = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_ANGLE_TOL    = 2'd3;

  localparam logic [15:0] RECOVER_GAIN_RST = 16'd655;
  localparam logic [15:0] TURN_GAIN_RST    = 16'd655;
  localparam logic [14:0] TURN_LIMIT_RST   = 15'd16384;
  localparam logic [15:0] ANGLE_TOL_RST    = 16'd200;

  localparam logic signed [47:0] Q_MAX = 48'sd32767;
  localparam logic signed [47:0] Q_MIN = -48'sd32768;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [23:0] turn_angle;
    logic [15:0]        timeout_ms;
    logic signed [23:0] gyro_raw;
    logic               is_autonomous;
    logic [9:0]         elapsed_ms;
  } dhc_in_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               straight_active;
    logic               turn_active;
  } dhc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;
    logic do_cmd;
    logic do_head;
    logic do_m1;
    logic do_m2;
    logic do_m3;
    logic do_wb;
    logic load_out;
  } dhc_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic loop_run;
  } dhc_sts_t;

  function automatic logic signed [15:0] sat_q(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > Q_MAX) begin
      r = 16'sh7FFF;
    end else if (v < Q_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/dhc_ctrl.sv
// ----------------------------------------------------------------------------
// dhc_ctrl
// Sequencer of the heading controller: steps the datapath through one word
// and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dhc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dhc_pkg::dhc_ctl_t      ctl_o,
  input  wire dhc_pkg::dhc_sts_t sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_M1   = 3'd3;
  localparam logic [2:0] S_M2   = 3'd4;
  localparam logic [2:0] S_M3   = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.cap = 1'b1;
          state_d   = S_CMD;
        end
      end
      S_CMD: begin
        ctl_o.do_cmd = 1'b1;
        state_d      = S_HEAD;
      end
      S_HEAD: begin
        ctl_o.do_head = 1'b1;
        // loop state is settled once the command has acted
        state_d = sts_i.loop_run ? S_M1 : S_DONE;
      end
      S_M1: begin
        ctl_o.do_m1 = 1'b1;
        state_d     = S_M2;
      end
      S_M2: begin
        ctl_o.do_m2 = 1'b1;
        state_d     = S_M3;
      end
      S_M3: begin
        ctl_o.do_m3 = 1'b1;
        state_d     = S_WB;
      end
      S_WB: begin
        ctl_o.do_wb = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `DHC_ASSERT(a_accept_starts, (in_valid_i && in_ready_o) |=> (state_q == S_CMD), "no start")
  `DHC_ASSERT(a_no_overwrite, ctl_o.load_out |-> (!out_valid_q || out_ready_i), "overwrite")
  `DHC_ASSERT(a_wb_then_done, (state_q == S_WB) |=> (state_q == S_DONE), "done skipped")

endmodule

`default_nettype wire

### design/dhc_datapath.sv
// ----------------------------------------------------------------------------
// dhc_datapath
// State, configuration registers and arithmetic of the heading controller.
// Straight drive product is built from two partial products over two steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dhc_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dhc_pkg::dhc_ctl_t            ctl_i,
  output dhc_pkg::dhc_sts_t                 sts_o,
  input  wire dhc_pkg::dhc_in_t             in_data_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [dhc_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  wire logic [dhc_pkg::CFG_DW-1:0]   cfg_wdata_i,
  output dhc_pkg::dhc_out_t                 out_data_o
);

  // configuration
  logic [15:0] rec_gain_q, turn_gain_q, tol_q;
  logic [14:0] limit_q;

  // captured word and intermediate results
  dhc_pkg::dhc_in_t   in_q;
  logic signed [24:0] heading_q;
  logic signed [40:0] m1_q;
  logic signed [25:0] rem_q;
  logic signed [36:0] phi_q;
  logic [36:0]        plo_q;
  logic signed [42:0] tprod_q;
  logic               near_q;
  logic signed [57:0] p_q;
  dhc_pkg::dhc_out_t  out_q;

  // controller state
  logic signed [15:0] held_l_q, held_l_d, held_r_q, held_r_d;
  logic signed [15:0] st_l_q, st_l_d, st_r_q, st_r_d;
  logic signed [23:0] gz_q, gz_d;
  logic [16:0]        timer_q, timer_d;
  logic               str_on_q, str_on_d, trn_on_q, trn_on_d;
  logic signed [15:0] spd_q, spd_d;
  logic [15:0]        str_time_q, str_time_d;
  logic signed [23:0] tgt_q, tgt_d;
  logic [15:0]        trn_time_q, trn_time_d;

  logic signed [47:0] a_w, b_w, half_a;
  logic [17:0]        timer_sum;
  logic [16:0]        timer_sat;
  logic signed [15:0] sneg;
  logic signed [25:0] tol_s;
  logic signed [41:0] pq, drive, lim_s;
  logic               str_go, trn_go;

  assign a_w       = 48'(in_q.value_a);
  assign b_w       = 48'(in_q.value_b);
  assign half_a    = a_w >>> 1;
  assign timer_sum = {1'b0, timer_q} + 18'(in_q.elapsed_ms);
  assign timer_sat = timer_sum[17] ? '1 : timer_sum[16:0];
  assign sneg      = (spd_q > 16'sd0) ? -spd_q : spd_q;
  assign tol_s     = $signed({10'd0, tol_q});
  assign pq        = $signed(p_q[57:16]);
  assign drive     = $signed(tprod_q[42:1]);
  assign lim_s     = $signed({27'd0, limit_q});
  assign str_go    = (timer_q < 17'(str_time_q)) && in_q.is_autonomous;
  assign trn_go    = (timer_q < 17'(trn_time_q)) && in_q.is_autonomous;

  assign sts_o.loop_run = (in_q.command != dhc_pkg::CMD_STATEAUTO)
                       && (in_q.command != dhc_pkg::CMD_STATEOTHER)
                       && (str_on_q || trn_on_q);

  assign out_data_o = out_q;

  always_comb begin
    held_l_d   = held_l_q;
    held_r_d   = held_r_q;
    st_l_d     = st_l_q;
    st_r_d     = st_r_q;
    gz_d       = gz_q;
    timer_d    = timer_q;
    str_on_d   = str_on_q;
    trn_on_d   = trn_on_q;
    spd_d      = spd_q;
    str_time_d = str_time_q;
    tgt_d      = tgt_q;
    trn_time_d = trn_time_q;

    if (ctl_i.do_cmd) begin
      timer_d = timer_sat;
      case (in_q.command)
        dhc_pkg::CMD_TANK: begin
          str_on_d = 1'b0;
          trn_on_d = 1'b0;
          held_l_d = dhc_pkg::sat_q(a_w);
          held_r_d = dhc_pkg::sat_q(-b_w);
        end
        dhc_pkg::CMD_ARCADE: begin
          str_on_d = 1'b0;
          trn_on_d = 1'b0;
          held_l_d = dhc_pkg::sat_q(b_w + half_a);
          held_r_d = dhc_pkg::sat_q(half_a - b_w);
        end
        dhc_pkg::CMD_STRAIGHT: begin
          timer_d    = '0;
          gz_d       = in_q.gyro_raw;
          spd_d      = in_q.value_a;
          str_time_d = in_q.timeout_ms;
          str_on_d   = 1'b1;
          trn_on_d   = 1'b0;
        end
        dhc_pkg::CMD_TURN: begin
          timer_d    = '0;
          gz_d       = in_q.gyro_raw;
          tgt_d      = in_q.turn_angle;
          trn_time_d = in_q.timeout_ms;
          str_on_d   = 1'b0;
          trn_on_d   = 1'b1;
        end
        dhc_pkg::CMD_AUTORUN: begin
          str_on_d = 1'b0;
          trn_on_d = 1'b0;
          st_l_d   = '0;
          st_r_d   = '0;
          timer_d  = '0;
          gz_d     = in_q.gyro_raw;
        end
        dhc_pkg::CMD_AUTODONE, dhc_pkg::CMD_STOP: begin
          str_on_d = 1'b0;
          trn_on_d = 1'b0;
          st_l_d   = '0;
          st_r_d   = '0;
          held_l_d = '0;
          held_r_d = '0;
          gz_d     = in_q.gyro_raw;
        end
        dhc_pkg::CMD_MOVE: begin
          str_on_d = 1'b0;
          trn_on_d = 1'b0;
          st_l_d   = dhc_pkg::sat_q(a_w);
          st_r_d   = dhc_pkg::sat_q(-b_w);
          held_l_d = dhc_pkg::sat_q(a_w);
          held_r_d = dhc_pkg::sat_q(-b_w);
        end
        dhc_pkg::CMD_ZERO: begin
          gz_d = in_q.gyro_raw;
        end
        dhc_pkg::CMD_STATEAUTO: begin
          held_l_d = st_l_q;
          held_r_d = st_r_q;
        end
        dhc_pkg::CMD_STATEOTHER: begin
          held_l_d = '0;
          held_r_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (ctl_i.do_wb) begin
      if (str_on_q) begin
        if (str_go) begin
          // p already carries the sign flip: q = floor(-|s|*h*g / 2^16)
          st_l_d   = dhc_pkg::sat_q(48'(pq) + 48'(spd_q));
          st_r_d   = dhc_pkg::sat_q(48'(pq) - 48'(spd_q));
          held_l_d = dhc_pkg::sat_q(48'(pq) + 48'(spd_q));
          held_r_d = dhc_pkg::sat_q(48'(pq) - 48'(spd_q));
        end else begin
          str_on_d = 1'b0;
          st_l_d   = '0;
          st_r_d   = '0;
          held_l_d = '0;
          held_r_d = '0;
        end
      end else if (trn_on_q) begin
        if (trn_go && !near_q) begin
          if (drive > lim_s) begin
            held_l_d = 16'(lim_s);
            held_r_d = 16'(lim_s);
          end else if (drive < -lim_s) begin
            held_l_d = 16'(-lim_s);
            held_r_d = 16'(-lim_s);
          end else begin
            held_l_d = 16'(drive);
            held_r_d = 16'(drive);
          end
        end else begin
          trn_on_d = 1'b0;
          held_l_d = '0;
          held_r_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_gain_q  <= dhc_pkg::RECOVER_GAIN_RST;
      turn_gain_q <= dhc_pkg::TURN_GAIN_RST;
      limit_q     <= dhc_pkg::TURN_LIMIT_RST;
      tol_q       <= dhc_pkg::ANGLE_TOL_RST;
      held_l_q    <= '0;
      held_r_q    <= '0;
      st_l_q      <= '0;
      st_r_q      <= '0;
      gz_q        <= '0;
      timer_q     <= '0;
      str_on_q    <= 1'b0;
      trn_on_q    <= 1'b0;
      spd_q       <= '0;
      str_time_q  <= '0;
      tgt_q       <= '0;
      trn_time_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          dhc_pkg::CFG_RECOVER_GAIN: rec_gain_q  <= cfg_wdata_i;
          dhc_pkg::CFG_TURN_GAIN:    turn_gain_q <= cfg_wdata_i;
          dhc_pkg::CFG_TURN_LIMIT:   limit_q     <= cfg_wdata_i[14:0];
          dhc_pkg::CFG_ANGLE_TOL:    tol_q       <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      held_l_q   <= held_l_d;
      held_r_q   <= held_r_d;
      st_l_q     <= st_l_d;
      st_r_q     <= st_r_d;
      gz_q       <= gz_d;
      timer_q    <= timer_d;
      str_on_q   <= str_on_d;
      trn_on_q   <= trn_on_d;
      spd_q      <= spd_d;
      str_time_q <= str_time_d;
      tgt_q      <= tgt_d;
      trn_time_q <= trn_time_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      in_q <= in_data_i;
    end
    if (ctl_i.do_head) begin
      heading_q <= 25'(in_q.gyro_raw) - 25'(gz_q);
    end
    if (ctl_i.do_m1) begin
      m1_q  <= sneg * heading_q;
      rem_q <= 26'(tgt_q) - 26'(heading_q);
    end
    if (ctl_i.do_m2) begin
      phi_q   <= $signed(m1_q[40:21]) * $signed({1'b0, rec_gain_q});
      plo_q   <= m1_q[20:0] * rec_gain_q;
      tprod_q <= rem_q * $signed({1'b0, turn_gain_q});
      near_q  <= (rem_q < tol_s) && (rem_q > -tol_s);
    end
    if (ctl_i.do_m3) begin
      p_q <= (58'(phi_q) <<< 21) + $signed({21'd0, plo_q});
    end
    if (ctl_i.load_out) begin
      out_q.left_drive      <= held_l_q;
      out_q.right_drive     <= held_r_q;
      out_q.straight_active <= str_on_q;
      out_q.turn_active     <= trn_on_q;
    end
  end

endmodule

`default_nettype wire

### design/differential_drive_heading_controller.sv
// ----------------------------------------------------------------------------
// differential_drive_heading_controller
// Drive command decoder with gyro heading hold for straight drive and a
// proportional closed loop turn.
// ----------------------------------------------------------------------------
//
//   channel  signals                              dir  handshake
//   input    in_valid_i / in_ready_o / in_data_i  in   valid-ready
//   output   out_valid_o / out_ready_i / out_data_o out valid-ready
//   config   cfg_we_i / cfg_addr_i / cfg_wdata_i  in   write strobe
//
// One word at a time. A word that runs a straight drive or turn step passes
// through command, heading, three multiply steps, writeback and result load;
// any other word goes from heading straight to result load.
// The result sits in an output register; the next word is taken while it
// waits. A stalled output holds the sequencer in its last step.
// Reset clears all loop state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_heading_controller (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire dhc_pkg::dhc_in_t             in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output dhc_pkg::dhc_out_t                 out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [dhc_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  wire logic [dhc_pkg::CFG_DW-1:0]   cfg_wdata_i
);

  dhc_pkg::dhc_ctl_t ctl;
  dhc_pkg::dhc_sts_t sts;

  dhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  dhc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### bench/dhc_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive checker
// Watches the command, result and register channels of the heading
// controller, predicts each result word from its own copy of the loop state
// and compares it field by field with what comes out.
// ----------------------------------------------------------------------------

module dhc_drive_checker
  import dhc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  dhc_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  dhc_out_t             out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_addr_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned TIMER_TOP  = 131071;

  logic [15:0]        recover_gain_q, turn_gain_q, angle_tol_q;
  logic [14:0]        turn_limit_q;
  logic signed [15:0] held_left, held_right, stored_left, stored_right;
  logic signed [15:0] straight_speed;
  logic signed [23:0] gyro_zero, turn_target;
  logic [16:0]        run_timer;
  logic [15:0]        straight_time, turn_time;
  logic               straight_on, turn_on;

  dhc_out_t    drive_expect_q[$];
  dhc_out_t    predicted, oldest;
  int unsigned mismatch_total;

  function automatic logic signed [15:0] clamp_q15(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // one command word through the controller: timer, command, loop steps
  task automatic drive_for_word(input dhc_in_t w, output dhc_out_t r);
    longint      a, b, g, gz, hd, s, p, lft, rgt, rem, tol, drv, lim, gain;
    int unsigned t;
    logic        loop_step;
    a = $signed(w.value_a);
    b = $signed(w.value_b);
    g = $signed(w.gyro_raw);
    loop_step = 1'b1;
    t = run_timer + w.elapsed_ms;
    run_timer = (t > TIMER_TOP) ? 17'h1ffff : t[16:0];

    case (w.command)
      CMD_TANK: begin
        straight_on = 1'b0;
        turn_on = 1'b0;
        held_left = clamp_q15(a);
        held_right = clamp_q15(-b);
      end
      CMD_ARCADE: begin
        straight_on = 1'b0;
        turn_on = 1'b0;
        held_left = clamp_q15((2 * b + a) >>> 1);
        held_right = clamp_q15((a - 2 * b) >>> 1);
      end
      CMD_STRAIGHT: begin
        run_timer = '0;
        gyro_zero = w.gyro_raw;
        straight_speed = w.value_a;
        straight_time = w.timeout_ms;
        straight_on = 1'b1;
        turn_on = 1'b0;
      end
      CMD_TURN: begin
        run_timer = '0;
        gyro_zero = w.gyro_raw;
        turn_target = w.turn_angle;
        turn_time = w.timeout_ms;
        straight_on = 1'b0;
        turn_on = 1'b1;
      end
      CMD_AUTORUN: begin
        straight_on = 1'b0;
        turn_on = 1'b0;
        stored_left = '0;
        stored_right = '0;
        run_timer = '0;
        gyro_zero = w.gyro_raw;
      end
      CMD_AUTODONE, CMD_STOP: begin
        straight_on = 1'b0;
        turn_on = 1'b0;
        stored_left = '0;
        stored_right = '0;
        held_left = '0;
        held_right = '0;
        gyro_zero = w.gyro_raw;
      end
      CMD_MOVE: begin
        straight_on = 1'b0;
        turn_on = 1'b0;
        stored_left = clamp_q15(a);
        stored_right = clamp_q15(-b);
        held_left = stored_left;
        held_right = stored_right;
      end
      CMD_ZERO: begin
        gyro_zero = w.gyro_raw;
      end
      CMD_STATEAUTO: begin
        held_left = stored_left;
        held_right = stored_right;
        loop_step = 1'b0;
      end
      CMD_STATEOTHER: begin
        held_left = '0;
        held_right = '0;
        loop_step = 1'b0;
      end
      default: ;
    endcase

    // heading kept at full width, no wrap
    gz = gyro_zero;
    hd = g - gz;

    if (loop_step && straight_on) begin
      if (run_timer < straight_time && w.is_autonomous) begin
        s = straight_speed;
        gain = recover_gain_q;
        p = s * hd * gain;
        lft = 0;
        rgt = 0;
        if (s > 0) begin
          lft = (s * 65536 - p) >>> 16;
          rgt = (-s * 65536 - p) >>> 16;
        end else if (s < 0) begin
          lft = (s * 65536 + p) >>> 16;
          rgt = (-s * 65536 + p) >>> 16;
        end
        stored_left = clamp_q15(lft);
        stored_right = clamp_q15(rgt);
      end else begin
        straight_on = 1'b0;
        stored_left = '0;
        stored_right = '0;
      end
      held_left = stored_left;
      held_right = stored_right;
    end

    if (loop_step && turn_on) begin
      drv = 0;
      if (run_timer < turn_time && w.is_autonomous) begin
        rem = turn_target;
        rem = rem - hd;
        tol = angle_tol_q;
        if (rem < tol && rem > -tol) begin
          turn_on = 1'b0;
        end else begin
          gain = turn_gain_q;
          lim = turn_limit_q;
          drv = (rem * gain) >>> 1;
          if (drv > lim) drv = lim;
          if (drv < -lim) drv = -lim;
        end
      end else begin
        turn_on = 1'b0;
      end
      held_left = clamp_q15(drv);
      held_right = clamp_q15(drv);
    end

    r.left_drive = held_left;
    r.right_drive = held_right;
    r.straight_active = straight_on;
    r.turn_active = turn_on;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recover_gain_q = RECOVER_GAIN_RST;
      turn_gain_q = TURN_GAIN_RST;
      turn_limit_q = TURN_LIMIT_RST;
      angle_tol_q = ANGLE_TOL_RST;
      held_left = '0;
      held_right = '0;
      stored_left = '0;
      stored_right = '0;
      straight_speed = '0;
      gyro_zero = '0;
      turn_target = '0;
      run_timer = '0;
      straight_time = '0;
      turn_time = '0;
      straight_on = 1'b0;
      turn_on = 1'b0;
      drive_expect_q.delete();
      mismatch_total = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (drive_expect_q.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_MAX) begin
            $display("%0t: drive word with nothing pending: L=%0d R=%0d S=%0b T=%0b",
                     $realtime, out_data_i.left_drive, out_data_i.right_drive,
                     out_data_i.straight_active, out_data_i.turn_active);
          end
        end else begin
          oldest = drive_expect_q.pop_front();
          if (out_data_i.left_drive !== oldest.left_drive ||
              out_data_i.right_drive !== oldest.right_drive ||
              out_data_i.straight_active !== oldest.straight_active ||
              out_data_i.turn_active !== oldest.turn_active) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_MAX) begin
              $display("%0t: drive mismatch: exp L=%0d R=%0d S=%0b T=%0b got L=%0d R=%0d S=%0b T=%0b",
                       $realtime, oldest.left_drive, oldest.right_drive,
                       oldest.straight_active, oldest.turn_active,
                       out_data_i.left_drive, out_data_i.right_drive,
                       out_data_i.straight_active, out_data_i.turn_active);
            end
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_RECOVER_GAIN: recover_gain_q = cfg_wdata_i;
          CFG_TURN_GAIN:    turn_gain_q = cfg_wdata_i;
          CFG_TURN_LIMIT:   turn_limit_q = cfg_wdata_i[14:0];
          CFG_ANGLE_TOL:    angle_tol_q = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        drive_for_word(in_data_i, predicted);
        drive_expect_q.push_back(predicted);
      end

      mismatch_count_o <= mismatch_total;
      pending_o <= drive_expect_q.size();
    end
  end

endmodule

### bench/differential_drive_heading_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading controller bench
// Directed words for the drive extremes, every command and the loop exits,
// then random straight drives, turns and manual commands over several
// register settings and handshake pressure phases. A checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------

module differential_drive_heading_controller_test;
  import dhc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PHASE_WORDS  = 110;
  // codes above the last command act as a tick
  localparam logic [3:0]  CMD_SPARE    = 4'd15;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  dhc_in_t     in_data = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  dhc_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches;
  int unsigned pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  differential_drive_heading_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  dhc_drive_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("differential_drive_heading_controller_test: FAIL");
      $finish;
    end
  end

  function automatic dhc_in_t mk_word(input logic [3:0] cmd, input logic [15:0] a,
                                      input logic [15:0] b, input logic [23:0] ang,
                                      input logic [15:0] tmo, input logic [23:0] g,
                                      input logic auto, input logic [9:0] el);
    dhc_in_t w;
    w.command = cmd;
    w.value_a = a;
    w.value_b = b;
    w.turn_angle = ang;
    w.timeout_ms = tmo;
    w.gyro_raw = g;
    w.is_autonomous = auto;
    w.elapsed_ms = el;
    return w;
  endfunction

  function automatic dhc_in_t rand_word();
    return mk_word(4'($urandom_range(15)), 16'($urandom()), 16'($urandom()),
                   24'($urandom()), 16'($urandom()), 24'($urandom()),
                   1'($urandom()), 10'($urandom()));
  endfunction

  // enter and leave on a rising edge; valid stays up between back to back words
  task automatic send_word(input dhc_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic write_regs(input logic [15:0] rg, input logic [15:0] tg,
                            input logic [15:0] tl, input logic [15:0] tol);
    logic [15:0] vals [4];
    vals[CFG_RECOVER_GAIN] = rg;
    vals[CFG_TURN_GAIN] = tg;
    vals[CFG_TURN_LIMIT] = tl;
    vals[CFG_ANGLE_TOL] = tol;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_AW'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // pending is registered, so step a clock edge before looking at it
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_straight();
    dhc_in_t w;
    int      g0, drift, n;
    logic [15:0] spd;
    g0 = int'($urandom_range(8000000)) - 4000000;
    spd = ($urandom_range(3) == 0) ? 16'($urandom())
                                   : 16'(int'($urandom_range(16000)) - 8000);
    send_word(mk_word(CMD_STRAIGHT, spd, 16'($urandom()), 24'($urandom()),
                      16'($urandom_range(3000, 40)), 24'(g0), 1'b1,
                      10'($urandom_range(1023))));
    n = $urandom_range(10, 2);
    drift = 0;
    for (int i = 0; i < n; i++) begin
      drift += int'($urandom_range(400)) - 200;
      w = mk_word(CMD_TICK, 16'($urandom()), 16'($urandom()), 24'($urandom()),
                  16'($urandom()), 24'(g0 + drift), 1'($urandom_range(19) != 0),
                  10'($urandom_range(250)));
      case ($urandom_range(11))
        0: w.command = CMD_STATEAUTO;
        1: w.command = CMD_STATEOTHER;
        2: w.command = CMD_ZERO;
        default: ;
      endcase
      send_word(w);
    end
  endtask

  task automatic run_turn();
    dhc_in_t w;
    int      g0, angle, n;
    g0 = int'($urandom_range(8000000)) - 4000000;
    angle = ($urandom_range(7) == 0) ? int'($urandom_range(8000000)) - 4000000
                                     : int'($urandom_range(36000)) - 18000;
    send_word(mk_word(CMD_TURN, 16'($urandom()), 16'($urandom()), 24'(angle),
                      16'($urandom_range(4000, 40)), 24'(g0), 1'b1,
                      10'($urandom_range(1023))));
    n = $urandom_range(12, 3);
    for (int i = 0; i < n; i++) begin
      // heading walks toward the target with some noise
      w = mk_word(CMD_TICK, 16'($urandom()), 16'($urandom()), 24'($urandom()),
                  16'($urandom()),
                  24'(g0 + angle / n * (i + 1) + int'($urandom_range(600)) - 300),
                  1'($urandom_range(19) != 0), 10'($urandom_range(300)));
      if ($urandom_range(11) == 0) w.command = CMD_STATEAUTO;
      send_word(w);
    end
  endtask

  task automatic run_manual();
    dhc_in_t w;
    w = rand_word();
    case ($urandom_range(9))
      0: w.command = CMD_TANK;
      1: w.command = CMD_ARCADE;
      2: w.command = CMD_MOVE;
      3: w.command = CMD_STOP;
      4: w.command = CMD_AUTORUN;
      5: w.command = CMD_AUTODONE;
      6: w.command = CMD_STATEAUTO;
      7: w.command = CMD_STATEOTHER;
      8: w.command = CMD_ZERO;
      default: w.command = CMD_TICK;
    endcase
    send_word(w);
  endtask

  initial begin
    int unsigned pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at reset register values
    send_word(mk_word(CMD_TANK, 16'h7fff, 16'h8000, '0, '0, '0, 1'b0, '0));
    send_word(mk_word(CMD_TANK, 16'h8000, 16'h7fff, '0, '0, '0, 1'b1, '0));
    send_word(mk_word(CMD_ARCADE, 16'h7fff, 16'h7fff, '0, '0, '0, 1'b0, '0));
    send_word(mk_word(CMD_ARCADE, 16'h8000, 16'h8000, '0, '0, '0, 1'b0, '0));
    send_word(mk_word(CMD_ARCADE, 16'hffff, 16'h0000, '0, '0, '0, 1'b0, '0));
    send_word(mk_word(CMD_MOVE, 16'd1234, 16'h8000, '0, '0, '0, 1'b0, '0));
    send_word(mk_word(CMD_STATEOTHER, '0, '0, '0, '0, '0, 1'b0, '0));
    send_word(mk_word(CMD_STATEAUTO, '0, '0, '0, '0, '0, 1'b0, '0));
    send_word(mk_word(CMD_ZERO, '0, '0, '0, '0, 24'h7fffff, 1'b0, '0));
    // straight at full speed, large heading error, then loss of autonomous
    send_word(mk_word(CMD_STRAIGHT, 16'h7fff, '0, '0, 16'hffff, 24'h800000,
                      1'b1, 10'h3ff));
    send_word(mk_word(CMD_TICK, '0, '0, '0, '0, 24'h8001f4, 1'b1, 10'd10));
    send_word(mk_word(CMD_TICK, '0, '0, '0, '0, 24'h7fffff, 1'b1, 10'd10));
    send_word(mk_word(CMD_TICK, '0, '0, '0, '0, 24'h7fffff, 1'b0, 10'd10));
    // reverse straight ending on timeout
    send_word(mk_word(CMD_STRAIGHT, 16'h8000, '0, '0, 16'd100, '0, 1'b1, '0));
    send_word(mk_word(CMD_TICK, '0, '0, '0, '0, 24'(-300), 1'b1, 10'd50));
    send_word(mk_word(CMD_TICK, '0, '0, '0, '0, 24'(-300), 1'b1, 10'h3ff));
    // zero speed straight
    send_word(mk_word(CMD_STRAIGHT, '0, '0, '0, 16'd1000, 24'd77, 1'b1, '0));
    send_word(mk_word(CMD_TICK, '0, '0, '0, '0, 24'd500, 1'b1, 10'd5));
    // turn finishing inside tolerance
    send_word(mk_word(CMD_TURN, '0, '0, 24'd9000, 16'hffff, 24'd100, 1'b1, '0));
    send_word(mk_word(CMD_TICK, '0, '0, '0, '0, 24'd9050, 1'b1, 10'd20));
    // zero timeout ends the turn on its start word
    send_word(mk_word(CMD_TURN, '0, '0, 24'h800000, '0, '0, 1'b1, '0));
    // far target, drive clamps at the limit
    send_word(mk_word(CMD_TURN, '0, '0, 24'h7fffff, 16'd5000, 24'h800000, 1'b1, '0));
    send_word(mk_word(CMD_TICK, '0, '0, '0, '0, 24'h800064, 1'b1, 10'd10));
    send_word(mk_word(CMD_AUTORUN, '0, '0, '0, '0, 24'd42, 1'b1, '0));
    send_word(mk_word(CMD_AUTODONE, '0, '0, '0, '0, 24'd9, 1'b1, '0));
    send_word(mk_word(CMD_STOP, '0, '0, '0, '0, 24'hfffff0, 1'b0, '0));
    send_word(mk_word(CMD_SPARE, 16'hffff, 16'hffff, 24'hffffff, 16'hffff,
                      24'hffffff, 1'b1, 10'h3ff));

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_regs(16'hffff, 16'hffff, 16'hffff, 16'h0000);
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 0;
          write_regs(16'h0000, 16'h0000, 16'h0000, 16'hffff);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 55;
          write_regs(16'($urandom_range(2000)), 16'($urandom_range(3000)),
                     16'($urandom_range(32767)), 16'($urandom_range(600)));
        end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
          write_regs(16'($urandom_range(1500)), 16'($urandom()),
                     16'($urandom_range(32767)), 16'($urandom_range(400)));
        end
      endcase
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        pick = $urandom_range(19);
        if (pick < 8) begin
          run_straight();
        end else if (pick < 14) begin
          run_turn();
        end else if (pick < 18) begin
          run_manual();
        end else begin
          send_word(rand_word());
        end
      end
    end
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("differential_drive_heading_controller_test: PASS");
    end else begin
      $display("differential_drive_heading_controller_test: FAIL");
    end
    $finish;
  end

endmodule
